/* src/assert_macros.svh */
// Concurrent assertion helpers used by the datapath RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that an antecedent is followed in the next cycle by a consequent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ppq_pkg.sv */
package ppq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = 7;
	localparam int DEST_W      = 32;
	localparam int HANDLE_W    = 16;
	localparam int ENTRY_W     = DEST_W + HANDLE_W;

	localparam logic [CNT_W-1:0] MAX_RESET = CNT_W'(QUEUE_DEPTH);

	// Opcodes.
	localparam logic [2:0] OP_ENQ    = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_DROP   = 3'd2;
	localparam logic [2:0] OP_SEND   = 3'd3;
	localparam logic [2:0] OP_FLUSH  = 3'd4;

	// Reply kinds.
	localparam logic [1:0] KIND_ENQ    = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_REL    = 2'd2;

	// Release actions.
	localparam logic [1:0] ACT_FWD    = 2'd0;
	localparam logic [1:0] ACT_DROP   = 2'd1;
	localparam logic [1:0] ACT_NOTIFY = 2'd2;

	typedef struct packed {
		logic [2:0]          opcode;
		logic [DEST_W-1:0]   dest_addr;
		logic [HANDLE_W-1:0] packet_handle;
		logic                route_present;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          reply_kind;
		logic                accepted;
		logic                found;
		logic                entry_present;
		logic [HANDLE_W-1:0] released_handle;
		logic [1:0]          action;
		logic [CNT_W-1:0]    release_count;
		logic                last;
		logic [CNT_W-1:0]    occupancy;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENQ,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic latch;
		logic enq;
		logic scan;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
	} ctl_sts_t;

endpackage

/* src/ppq_ram.sv */
module ppq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/ppq_ctrl.sv */
module ppq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         opcode,
	input  ppq_pkg::ctl_sts_t  sts,
	output ppq_pkg::ctl_cmd_t  ctl,
	output logic               busy
);

	ppq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ppq_pkg::ST_IDLE: begin
				if (start) begin
					if (opcode == ppq_pkg::OP_ENQ) begin
						state_d = ppq_pkg::ST_ENQ;
					end else if (opcode inside {ppq_pkg::OP_LOOKUP, ppq_pkg::OP_DROP,
							ppq_pkg::OP_SEND, ppq_pkg::OP_FLUSH}) begin
						state_d = ppq_pkg::ST_SCAN;
					end
				end
			end
			ppq_pkg::ST_ENQ: state_d = ppq_pkg::ST_IDLE;
			ppq_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ppq_pkg::ST_FINISH;
				end
			end
			ppq_pkg::ST_FINISH: state_d = ppq_pkg::ST_IDLE;
			default: state_d = ppq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		case (state_q)
			ppq_pkg::ST_IDLE: begin
				busy      = 1'b0;
				ctl.latch = start;
			end
			ppq_pkg::ST_ENQ:    ctl.enq = 1'b1;
			ppq_pkg::ST_SCAN:   ctl.scan = 1'b1;
			ppq_pkg::ST_FINISH: ctl.finish = 1'b1;
			default:            busy = 1'b1;
		endcase
	end

endmodule

/* src/ppq_dp.sv */
`include "assert_macros.svh"

module ppq_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ppq_pkg::cmd_t             cmd,
	input  logic                      cfg_we,
	input  logic [ppq_pkg::CNT_W-1:0] cfg_wdata,
	input  ppq_pkg::ctl_cmd_t         ctl,
	output ppq_pkg::ctl_sts_t         sts,
	output logic                      strobe,
	output ppq_pkg::res_t             result
);

	// Control state.
	logic [ppq_pkg::CNT_W-1:0] count_q, max_q, total_q;
	logic [ppq_pkg::CNT_W-1:0] idx_q, keep_q, released_q, counted_q;
	logic [2:0]                op_q;
	logic                      route_q, found_q;
	logic                      rd_vld_s1, pend_vld_q, out_vld_q;

	// Payload.
	logic [ppq_pkg::DEST_W-1:0]   dest_q;
	logic [ppq_pkg::HANDLE_W-1:0] handle_q;
	ppq_pkg::res_t                pend_q, out_q;

	// Combinational.
	logic [ppq_pkg::ENTRY_W-1:0]  rd_data, wr_data;
	logic [ppq_pkg::DEST_W-1:0]   rd_dest;
	logic [ppq_pkg::HANDLE_W-1:0] rd_handle;
	logic [ppq_pkg::IDX_W-1:0]    wr_addr;
	logic                         wr_en, issue, is_release, hit, rel_hit, keep_wr, enq_ok;
	logic [ppq_pkg::CNT_W-1:0]    released_nx, counted_nx;
	logic [1:0]                   act;
	ppq_pkg::res_t                new_rep, out_d;
	logic                         out_vld_d;

	assign {rd_dest, rd_handle} = rd_data;

	assign issue       = ctl.scan && (idx_q < total_q);
	assign is_release  = (op_q != ppq_pkg::OP_LOOKUP);
	assign hit         = (op_q == ppq_pkg::OP_FLUSH) || (rd_dest == dest_q);
	assign rel_hit     = rd_vld_s1 && is_release && hit;
	assign keep_wr     = rd_vld_s1 && is_release && !hit;
	assign released_nx = released_q + 1'b1;
	assign enq_ok      = (count_q < max_q) && (count_q < ppq_pkg::CNT_W'(ppq_pkg::QUEUE_DEPTH));

	assign sts.scan_done = (idx_q == total_q) && !rd_vld_s1;

	// Action and running count for a released entry.
	always_comb begin
		act        = ppq_pkg::ACT_DROP;
		counted_nx = counted_q + 1'b1;
		case (op_q)
			ppq_pkg::OP_DROP: begin
				act = (counted_q == '0) ? ppq_pkg::ACT_NOTIFY : ppq_pkg::ACT_DROP;
			end
			ppq_pkg::OP_SEND: begin
				if (route_q) begin
					act = ppq_pkg::ACT_FWD;
				end else begin
					counted_nx = counted_q;
				end
			end
			default: act = ppq_pkg::ACT_DROP;
		endcase
	end

	always_comb begin
		new_rep                 = '0;
		new_rep.reply_kind      = ppq_pkg::KIND_REL;
		new_rep.entry_present   = 1'b1;
		new_rep.released_handle = rd_handle;
		new_rep.action          = act;
		new_rep.release_count   = counted_nx;
		new_rep.occupancy       = total_q - released_nx;
	end

	// Memory write: enqueue appends, release compacts survivors toward the head.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = keep_q[ppq_pkg::IDX_W-1:0];
		wr_data = {rd_dest, rd_handle};
		if (ctl.enq) begin
			wr_en   = enq_ok;
			wr_addr = count_q[ppq_pkg::IDX_W-1:0];
			wr_data = {dest_q, handle_q};
		end else if (keep_wr) begin
			wr_en = 1'b1;
		end
	end

	// Reply selection. Release replies are held back one match so that the
	// final one can carry the last flag.
	always_comb begin
		out_vld_d = 1'b0;
		out_d     = '0;
		if (ctl.enq) begin
			out_vld_d          = 1'b1;
			out_d.reply_kind   = ppq_pkg::KIND_ENQ;
			out_d.accepted     = enq_ok;
			out_d.last         = 1'b1;
			out_d.occupancy    = enq_ok ? count_q + 1'b1 : count_q;
		end else if (ctl.finish) begin
			out_vld_d = 1'b1;
			if (!is_release) begin
				out_d.reply_kind = ppq_pkg::KIND_LOOKUP;
				out_d.found      = found_q;
				out_d.last       = 1'b1;
				out_d.occupancy  = count_q;
			end else if (pend_vld_q) begin
				out_d      = pend_q;
				out_d.last = 1'b1;
			end else begin
				out_d.reply_kind = ppq_pkg::KIND_REL;
				out_d.last       = 1'b1;
				out_d.occupancy  = keep_q;
			end
		end else if (rel_hit && pend_vld_q) begin
			out_vld_d = 1'b1;
			out_d     = pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			max_q      <= ppq_pkg::MAX_RESET;
			total_q    <= '0;
			idx_q      <= '0;
			keep_q     <= '0;
			released_q <= '0;
			counted_q  <= '0;
			op_q       <= ppq_pkg::OP_ENQ;
			route_q    <= 1'b0;
			found_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			out_vld_q <= out_vld_d;
			rd_vld_s1 <= issue;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (ctl.latch) begin
				op_q       <= cmd.opcode;
				route_q    <= cmd.route_present;
				total_q    <= count_q;
				idx_q      <= '0;
				keep_q     <= '0;
				released_q <= '0;
				counted_q  <= '0;
				found_q    <= 1'b0;
				pend_vld_q <= 1'b0;
			end
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_vld_s1 && !is_release && hit) begin
				found_q <= 1'b1;
			end
			if (keep_wr) begin
				keep_q <= keep_q + 1'b1;
			end
			if (rel_hit) begin
				released_q <= released_nx;
				counted_q  <= counted_nx;
				pend_vld_q <= 1'b1;
			end
			if (ctl.enq && enq_ok) begin
				count_q <= count_q + 1'b1;
			end
			if (ctl.finish && is_release) begin
				count_q <= keep_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			dest_q   <= cmd.dest_addr;
			handle_q <= cmd.packet_handle;
		end
		if (rel_hit) begin
			pend_q <= new_rep;
		end
		out_q <= out_d;
	end

	ppq_ram #(
		.WIDTH(ppq_pkg::ENTRY_W),
		.DEPTH(ppq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(idx_q[ppq_pkg::IDX_W-1:0]),
		.rdata(rd_data)
	);

	assign strobe = out_vld_q;
	assign result = out_q;

	`ASSERT_CLK(a_count_cap, clk, arst_n, count_q <= ppq_pkg::CNT_W'(ppq_pkg::QUEUE_DEPTH),
		"entry count exceeds queue depth")
	`ASSERT_CLK(a_keep_behind, clk, arst_n, !rd_vld_s1 || (keep_q < idx_q),
		"compaction write would overtake the read pointer")
	`ASSERT_NEXT(a_last_gap, clk, arst_n, out_vld_q && out_q.last, !out_vld_q,
		"reply follows directly after a final reply")

endmodule

/* src/pending_packet_queue_by_destination_top.sv */
// Channel   Handshake             Payload             Direction
// command   start / busy          cmd (ppq_pkg::cmd_t) in
// result    strobe                result (res_t)      out
// config    cfg_we                cfg_wdata (7 bits)  in
//
// A command beat is taken at a rising edge with start high and busy low.
// An enqueue keeps busy high for one cycle after its beat is taken. A lookup,
// drop, send or flush scans every stored entry through the one read port of the
// entry memory and keeps busy high through the scan and the final reply state.
// Each result beat is shown for exactly one cycle with strobe high; the
// receiver cannot stall, so replies go out as soon as they are formed.
// Reset is asynchronous and active low; it empties the queue and sets the
// capacity limit to 64. Opcodes 5 to 7 are taken and produce no beat.

module pending_packet_queue_by_destination_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  ppq_pkg::cmd_t             cmd,
	output logic                      strobe,
	output ppq_pkg::res_t             result,
	input  logic                      cfg_we,
	input  logic [ppq_pkg::CNT_W-1:0] cfg_wdata
);

	// The controller sequences enqueue, scan and final reply; the datapath
	// holds the entry memory, counters and reply registers.
	ppq_pkg::ctl_cmd_t ctl;
	ppq_pkg::ctl_sts_t sts;

	ppq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(cmd.opcode),
		.sts   (sts),
		.ctl   (ctl),
		.busy  (busy)
	);

	// During a release scan, surviving entries are written back toward the
	// head of the memory while later entries are still being read, so the
	// arrival order of what remains is kept.
	ppq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.ctl      (ctl),
		.sts      (sts),
		.strobe   (strobe),
		.result   (result)
	);

endmodule
